// ----- rtl/core/cdfis_pkg.sv -----
// Shared types, widths and constants of the CDF inverse size sampler.
// No dependencies; every other file of the block but cdfis_ram imports this package.
package cdfis_pkg;

    localparam int SIZE_W    = 32;
    localparam int CDF_W     = 17;
    localparam int INDEX_W   = 5;
    localparam int COUNT_W   = 6;
    localparam int ENTRY_W   = SIZE_W + CDF_W;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam int DEFAULT_TABLE_DEPTH = 32;
    localparam int PERCENT_FRAC_BITS   = 10;

    // 100 percent in table units
    localparam logic [CDF_W-1:0] FULL_SCALE = CDF_W'(100 << PERCENT_FRAC_BITS);

    localparam logic ACTION_LOAD   = 1'b0;
    localparam logic ACTION_SAMPLE = 1'b1;

    localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = REG_IDX_W'(0);

    typedef struct packed {
        logic [CDF_W-1:0]  u;
        logic [CDF_W-1:0]  c0;
        logic [CDF_W-1:0]  c1;
        logic [SIZE_W-1:0] s0;
        logic [SIZE_W-1:0] s1;
    } interp_req_t;

    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] size;
    } interp_rsp_t;

    function automatic logic [SIZE_W-1:0] at_least_one(input logic [SIZE_W-1:0] v);
        return (v == '0) ? SIZE_W'(1) : v;
    endfunction

endpackage

// ----- rtl/core/cdfis_ram.sv -----
// Generic single-port RAM with registered read data.
// Standalone; no package dependency.
module cdfis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- rtl/core/cdfis_interp.sv -----
// Shared multiply / divide unit: linear interpolation with round half up.
// One multiplier used twice, then a radix-4 restoring divider; uses cdfis_pkg.
module cdfis_interp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  cdfis_pkg::interp_req_t req,
    output cdfis_pkg::interp_rsp_t rsp
);
    import cdfis_pkg::*;

    localparam int P_W    = SIZE_W + CDF_W + 2;
    localparam int N_W    = P_W + 1;
    localparam int Q_W    = SIZE_W + 2;
    localparam int REM_W  = CDF_W + 1;
    localparam int STEPS  = Q_W / 2;
    localparam int STEP_W = $clog2(STEPS + 1);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL0 = 3'd1;
    localparam logic [2:0] A_MUL1 = 3'd2;
    localparam logic [2:0] A_SUM  = 3'd3;
    localparam logic [2:0] A_CHK  = 3'd4;
    localparam logic [2:0] A_DIV  = 3'd5;
    localparam logic [2:0] A_OUT  = 3'd6;

    logic [2:0]               state_reg;
    logic [CDF_W-1:0]         den_reg;
    logic [CDF_W-1:0]         off_reg;
    logic [SIZE_W-1:0]        s0_reg;
    logic signed [SIZE_W:0]   diff_reg;
    logic signed [P_W-1:0]    prod_reg;
    logic signed [N_W-1:0]    acc_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [Q_W-1:0]           quo_reg;
    logic [STEP_W-1:0]        step_reg;

    logic signed [SIZE_W:0]   mul_a;
    logic signed [CDF_W:0]    mul_b;
    logic signed [P_W-1:0]    product;
    logic signed [N_W-1:0]    prod_dbl;
    logic signed [N_W-1:0]    den_ext;
    logic [REM_W-1:0]         dvs;
    logic [REM_W:0]           rem_w;
    logic [REM_W-1:0]         rem_next;
    logic [Q_W-1:0]           quo_next;

    // operand select for the one multiplier: s0*den first, then diff*off
    assign mul_a    = (state_reg == A_MUL0) ? $signed({1'b0, s0_reg}) : diff_reg;
    assign mul_b    = (state_reg == A_MUL0) ? $signed({1'b0, den_reg}) : $signed({1'b0, off_reg});
    assign product  = mul_a * mul_b;
    assign prod_dbl = $signed({prod_reg, 1'b0});
    assign den_ext  = $signed({{(N_W-CDF_W){1'b0}}, den_reg});
    assign dvs      = {den_reg, 1'b0};

    // two quotient bits per cycle
    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        rem_w    = '0;
        for (int k = 0; k < 2; k++)
        begin
            rem_w    = {rem_next, quo_next[Q_W-1]};
            quo_next = {quo_next[Q_W-2:0], 1'b0};
            if (rem_w >= {1'b0, dvs})
            begin
                rem_w       = rem_w - {1'b0, dvs};
                quo_next[0] = 1'b1;
            end
            rem_next = rem_w[REM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                A_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= A_MUL0;
                    end
                end
                A_MUL0:
                begin
                    state_reg <= A_MUL1;
                end
                A_MUL1:
                begin
                    state_reg <= A_SUM;
                end
                A_SUM:
                begin
                    state_reg <= A_CHK;
                end
                A_CHK:
                begin
                    step_reg  <= '0;
                    state_reg <= (acc_reg <= 0) ? A_OUT : A_DIV;
                end
                A_DIV:
                begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(STEPS - 1))
                    begin
                        state_reg <= A_OUT;
                    end
                end
                A_OUT:
                begin
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            A_IDLE:
            begin
                den_reg  <= req.c1 - req.c0;
                off_reg  <= req.u - req.c0;
                s0_reg   <= req.s0;
                diff_reg <= $signed({1'b0, req.s1}) - $signed({1'b0, req.s0});
            end
            A_MUL0:
            begin
                prod_reg <= product;
            end
            A_MUL1:
            begin
                prod_reg <= product;
                acc_reg  <= prod_dbl + den_ext;
            end
            A_SUM:
            begin
                acc_reg <= acc_reg + prod_dbl;
            end
            A_CHK:
            begin
                // quotient stays below 2^Q_W, so the top part is already below the divisor
                rem_reg <= REM_W'(acc_reg[N_W-2:Q_W]);
                quo_reg <= (acc_reg <= 0) ? Q_W'(1) : acc_reg[Q_W-1:0];
            end
            A_DIV:
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
            end
            default:
            begin
            end
        endcase
    end

    assign rsp.done = (state_reg == A_OUT);
    assign rsp.size = (quo_reg[Q_W-1:SIZE_W] != '0) ? '1 : at_least_one(quo_reg[SIZE_W-1:0]);

endmodule

// ----- rtl/core/cdfis_seq.sv -----
// Sequencer: table writes, linear search one entry per cycle, result register.
// Drives the table RAM and the shared interpolation unit; uses cdfis_pkg.
module cdfis_seq #(
    parameter int TABLE_DEPTH = cdfis_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             action,
    input  logic [cdfis_pkg::INDEX_W-1:0]    entry_index,
    input  logic [cdfis_pkg::SIZE_W-1:0]     entry_size,
    input  logic [cdfis_pkg::CDF_W-1:0]      entry_cdf,
    input  logic [cdfis_pkg::CDF_W-1:0]      sample_point,
    input  logic [cdfis_pkg::COUNT_W-1:0]    point_count,
    output logic                             ram_we,
    output logic [$clog2(TABLE_DEPTH)-1:0]   ram_addr,
    output logic [cdfis_pkg::ENTRY_W-1:0]    ram_wdata,
    input  logic [cdfis_pkg::ENTRY_W-1:0]    ram_rdata,
    output logic                             req_valid,
    output cdfis_pkg::interp_req_t           req,
    input  cdfis_pkg::interp_rsp_t           rsp,
    output logic                             done,
    output logic [cdfis_pkg::SIZE_W-1:0]     sample_size,
    output logic                             below_first,
    output logic                             beyond_last,
    output logic                             table_empty
);
    import cdfis_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_INTERP = 2'd2;

    logic [1:0]        state_reg;
    logic [CNT_W-1:0]  i_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CDF_W-1:0]  u_reg;
    logic [SIZE_W-1:0] prev_size_reg;
    logic [CDF_W-1:0]  prev_cdf_reg;
    logic              done_reg;
    logic [SIZE_W-1:0] size_reg;
    logic              below_reg;
    logic              beyond_reg;
    logic              empty_reg;

    logic              accept;
    logic              load_ok;
    logic [CDF_W-1:0]  cdf_sat;
    logic [CNT_W-1:0]  cnt_clamp;
    logic [SIZE_W-1:0] rd_size;
    logic [CDF_W-1:0]  rd_cdf;
    logic [CNT_W-1:0]  i_inc;
    logic              u_above;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign load_ok   = accept && (action == ACTION_LOAD) && (32'(entry_index) < TABLE_DEPTH);
    assign cdf_sat   = (entry_cdf > FULL_SCALE) ? FULL_SCALE : entry_cdf;
    assign cnt_clamp = (32'(point_count) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                         : CNT_W'(point_count);
    assign rd_size   = ram_rdata[ENTRY_W-1:CDF_W];
    assign rd_cdf    = ram_rdata[CDF_W-1:0];
    assign i_inc     = i_reg + CNT_W'(1);
    assign u_above   = (u_reg > rd_cdf);

    assign ram_we    = load_ok;
    assign ram_wdata = {entry_size, cdf_sat};

    // prefetch the next entry while scanning; entry 0 on a sample beat
    always_comb
    begin
        if (state_reg == ST_SCAN)
        begin
            ram_addr = i_inc[IDX_W-1:0];
        end
        else if (accept && (action == ACTION_LOAD))
        begin
            ram_addr = IDX_W'(entry_index);
        end
        else
        begin
            ram_addr = '0;
        end
    end

    assign req_valid = (state_reg == ST_SCAN) && !u_above && (i_reg != '0);
    assign req.u     = u_reg;
    assign req.c0    = prev_cdf_reg;
    assign req.c1    = rd_cdf;
    assign req.s0    = prev_size_reg;
    assign req.s1    = rd_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            i_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && (action == ACTION_SAMPLE))
                    begin
                        i_reg   <= '0;
                        cnt_reg <= cnt_clamp;
                        if (cnt_clamp == '0)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (u_above)
                    begin
                        if (i_inc >= cnt_reg)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            i_reg <= i_inc;
                        end
                    end
                    else if (i_reg == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_INTERP;
                    end
                end
                ST_INTERP:
                begin
                    if (rsp.done)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (action == ACTION_SAMPLE))
                begin
                    u_reg      <= sample_point;
                    size_reg   <= SIZE_W'(1);
                    below_reg  <= 1'b0;
                    beyond_reg <= 1'b0;
                    empty_reg  <= 1'b1;
                end
            end
            ST_SCAN:
            begin
                prev_size_reg <= rd_size;
                prev_cdf_reg  <= rd_cdf;
                size_reg      <= at_least_one(rd_size);
                below_reg     <= !u_above && (i_reg == '0);
                beyond_reg    <= u_above;
                empty_reg     <= 1'b0;
            end
            ST_INTERP:
            begin
                size_reg   <= rsp.size;
                below_reg  <= 1'b0;
                beyond_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    assign done        = done_reg;
    assign sample_size = size_reg;
    assign below_first = below_reg;
    assign beyond_last = beyond_reg;
    assign table_empty = empty_reg;

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $onehot0({below_reg, beyond_reg, empty_reg}))
        else $error("more than one case flag set on a result beat");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (size_reg != '0))
        else $error("result size is zero");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (i_reg < cnt_reg))
        else $error("search index ran past the point count");

    a_rsp_only_interp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> (state_reg == ST_INTERP))
        else $error("interpolation result with no request pending");

    a_req_to_interp: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid |=> (state_reg == ST_INTERP) && !done_reg)
        else $error("interpolation request did not hand over to the wait state");

endmodule

// ----- rtl/core/cdf_inverse_size_sampler.sv -----
// Top level of the CDF inverse size sampler: config register, table RAM,
// sequencer and shared interpolation unit. Uses cdfis_pkg, cdfis_ram,
// cdfis_seq and cdfis_interp.
//
//  channel   direction  handshake                     payload
//  -------   ---------  ----------------------------  ------------------------------------
//  command   in         start && !busy                action, entry_index, entry_size,
//                                                     entry_cdf, sample_point
//  result    out        done (one cycle, no stall)    sample_size, below_first,
//                                                     beyond_last, table_empty
//  config    in/out     APB, psel&penable&pwrite      point_count at byte address 0
//
// A load beat writes its table entry; busy stays low and the next beat may follow at once.
// A sample beat on an empty table gives its result in the next cycle, busy stays low.
// Otherwise the search reads one table entry per cycle from the RAM port until the
// answer is entry k's size, or it interpolates between entries k-1 and k (two
// passes through the multiplier, then the divider).
// Reset clears the point count and the control state; the table is not cleared.
// The receiver cannot stall: done marks a result for exactly one cycle.
module cdf_inverse_size_sampler #(
    parameter int TABLE_DEPTH = cdfis_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cdfis_pkg::ADDR_W-1:0]  paddr,
    input  logic [cdfis_pkg::DATA_W-1:0]  pwdata,
    output logic [cdfis_pkg::DATA_W-1:0]  prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic                          action,
    input  logic [cdfis_pkg::INDEX_W-1:0] entry_index,
    input  logic [cdfis_pkg::SIZE_W-1:0]  entry_size,
    input  logic [cdfis_pkg::CDF_W-1:0]   entry_cdf,
    input  logic [cdfis_pkg::CDF_W-1:0]   sample_point,
    output logic                          done,
    output logic [cdfis_pkg::SIZE_W-1:0]  sample_size,
    output logic                          below_first,
    output logic                          beyond_last,
    output logic                          table_empty
);
    import cdfis_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [COUNT_W-1:0]   point_count_reg;
    logic                 cfg_write;
    logic                 count_sel;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_addr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic                 req_valid;
    interp_req_t          req;
    interp_rsp_t          rsp;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign count_sel = (paddr[ADDR_W-1:2] == REG_POINT_COUNT);
    assign prdata    = count_sel ? DATA_W'(point_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
        end
        else if (cfg_write && count_sel)
        begin
            point_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    cdfis_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    cdfis_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .entry_index  (entry_index),
        .entry_size   (entry_size),
        .entry_cdf    (entry_cdf),
        .sample_point (sample_point),
        .point_count  (point_count_reg),
        .ram_we       (ram_we),
        .ram_addr     (ram_addr),
        .ram_wdata    (ram_wdata),
        .ram_rdata    (ram_rdata),
        .req_valid    (req_valid),
        .req          (req),
        .rsp          (rsp),
        .done         (done),
        .sample_size  (sample_size),
        .below_first  (below_first),
        .beyond_last  (beyond_last),
        .table_empty  (table_empty)
    );

    cdfis_interp u_interp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .rsp       (rsp)
    );

endmodule
